// ----- design/skt_pkg.sv -----
package skt_pkg;

  localparam int DEFAULT_DEPTH = 256;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 9;
  localparam int STATUS_W      = 3;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_BADRANGE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOTFOUND  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_PROBE,
    S_SHIFT,
    S_MOVE,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic        [DATA_W-1:0] usage;
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
    logic signed [DATA_W-1:0] rest;
  } record_t;

endpackage

// ----- design/skt_store.sv -----
module skt_store #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  skt_pkg::record_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output skt_pkg::record_t rd_data
);

  skt_pkg::record_t mem [TABLE_DEPTH];
  skt_pkg::record_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/sorted_key_table_insert_lookup_top.sv -----
// Sorted record table with binary-search insert and lookup over one record memory.
// Each halving step reads the middle record, then compares keys; once the window closes,
// the slot at its low end is read and checked unless it is past the last record. An insert
// moves each later record up one slot, then fills the gap; a bad range skips the search.
// One item at a time: the next is accepted the cycle after its result register is loaded,
// and a result not yet taken holds the block. Reset clears the record count, not the memory.
module sorted_key_table_insert_lookup_top #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_op,
  input  logic signed [31:0] in_key_id,
  input  logic [31:0] in_usage_code,
  input  logic signed [31:0] in_value_low,
  input  logic signed [31:0] in_value_high,
  input  logic signed [31:0] in_value_rest,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [8:0]  out_position,
  output logic [31:0] out_found_usage,
  output logic signed [31:0] out_found_low,
  output logic signed [31:0] out_found_high,
  output logic signed [31:0] out_found_rest,
  output logic [8:0]  out_occupancy
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = skt_pkg::POS_W;

  skt_pkg::state_t  state_r, state_nxt;
  skt_pkg::op_t     op_r, op_nxt;
  skt_pkg::record_t item_r, item_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  skt_pkg::status_t res_status_r, res_status_nxt;
  logic [CW-1:0]    res_pos_r, res_pos_nxt;
  skt_pkg::record_t res_found_r, res_found_nxt;

  logic             out_valid_r, out_valid_nxt;
  skt_pkg::status_t out_status_r, out_status_nxt;
  logic [PW-1:0]    out_pos_r, out_pos_nxt;
  skt_pkg::record_t out_found_r, out_found_nxt;
  logic [PW-1:0]    out_occ_r, out_occ_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  skt_pkg::record_t wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  skt_pkg::record_t rd_data;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    idx_dec;
  logic             resolve_miss;

  skt_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CW:1];
  assign idx_dec = idx_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    item_r       <= item_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_found_r  <= out_found_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    item_nxt       = item_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_found_nxt  = out_found_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = lo_r[AW-1:0];
    wr_data        = item_r;
    rd_en          = 1'b0;
    rd_addr        = mid[AW-1:0];
    resolve_miss   = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt         = skt_pkg::op_t'(in_op);
          item_nxt.key   = in_key_id;
          item_nxt.usage = in_usage_code;
          item_nxt.low   = in_value_low;
          item_nxt.high  = in_value_high;
          item_nxt.rest  = in_value_rest;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          res_found_nxt  = '0;
          res_pos_nxt    = '0;
          if (skt_pkg::op_t'(in_op) == skt_pkg::OP_INSERT &&
              !(in_value_low < in_value_high)) begin
            res_status_nxt = skt_pkg::ST_BADRANGE;
            state_nxt      = skt_pkg::S_DONE;
          end else begin
            state_nxt = skt_pkg::S_SEARCH;
          end
        end
      end
      skt_pkg::S_SEARCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid[AW-1:0];
          state_nxt = skt_pkg::S_CMP;
        end else if (lo_r < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = lo_r[AW-1:0];
          state_nxt = skt_pkg::S_PROBE;
        end else begin
          resolve_miss = 1'b1;
        end
      end
      skt_pkg::S_CMP: begin
        if ($signed(rd_data.key) < $signed(item_r.key)) begin
          lo_nxt = mid + CW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = skt_pkg::S_SEARCH;
      end
      skt_pkg::S_PROBE: begin
        if (rd_data.key == item_r.key) begin
          res_pos_nxt = lo_r;
          if (op_r == skt_pkg::OP_LOOKUP) begin
            res_status_nxt = skt_pkg::ST_FOUND;
            res_found_nxt  = rd_data;
          end else begin
            res_status_nxt = skt_pkg::ST_DUPLICATE;
          end
          state_nxt = skt_pkg::S_DONE;
        end else begin
          resolve_miss = 1'b1;
        end
      end
      skt_pkg::S_SHIFT: begin
        if (idx_r == lo_r) begin
          state_nxt = skt_pkg::S_WRITE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = skt_pkg::S_MOVE;
        end
      end
      skt_pkg::S_MOVE: begin
        // Move the record just read one slot up, working down toward the gap.
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = rd_data;
        idx_nxt   = idx_dec;
        state_nxt = skt_pkg::S_SHIFT;
      end
      skt_pkg::S_WRITE: begin
        wr_en          = 1'b1;
        wr_addr        = lo_r[AW-1:0];
        wr_data        = item_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = skt_pkg::ST_INSERTED;
        res_pos_nxt    = lo_r;
        state_nxt      = skt_pkg::S_DONE;
      end
      skt_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = PW'(res_pos_r);
          out_found_nxt  = res_found_r;
          out_occ_nxt    = PW'(count_r);
          state_nxt      = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skt_pkg::S_IDLE;
      end
    endcase

    if (resolve_miss) begin
      if (op_r == skt_pkg::OP_LOOKUP) begin
        res_status_nxt = skt_pkg::ST_NOTFOUND;
        res_pos_nxt    = '0;
        state_nxt      = skt_pkg::S_DONE;
      end else if (count_r == CW'(TABLE_DEPTH)) begin
        res_status_nxt = skt_pkg::ST_FULL;
        res_pos_nxt    = lo_r;
        state_nxt      = skt_pkg::S_DONE;
      end else begin
        idx_nxt   = count_r;
        state_nxt = skt_pkg::S_SHIFT;
      end
    end
  end

  assign in_ready        = (state_r == skt_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_found_usage = out_found_r.usage;
  assign out_found_low   = out_found_r.low;
  assign out_found_high  = out_found_r.high;
  assign out_found_rest  = out_found_r.rest;
  assign out_occupancy   = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("record count exceeds table depth");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skt_pkg::S_WRITE |=> count_r == $past(count_r) + CW'(1))
    else $error("record count did not grow after an insert write");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_SEARCH || state_r == skt_pkg::S_CMP) |->
      (lo_r <= hi_r && hi_r <= count_r))
    else $error("binary search window out of order");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_SHIFT || state_r == skt_pkg::S_MOVE) |->
      (idx_r >= lo_r && idx_r <= count_r && count_r != CW'(TABLE_DEPTH)))
    else $error("shift index outside the moved range");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    $changed(count_r) |-> $past(state_r) == skt_pkg::S_WRITE)
    else $error("record count changed outside an insert");

endmodule
